// ----- rtl/core/apcc_pkg.sv -----
package apcc_pkg;

  // Operation codes of an input item
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ZEN_START = 3'd0,
    CFG_ZEN_END   = 3'd1,
    CFG_ZEN_STEP  = 3'd2,
    CFG_NORTH     = 3'd3,
    CFG_EAST      = 3'd4,
    CFG_UP        = 3'd5,
    CFG_PATTERN   = 3'd6
  } cfg_reg_e;

  // Sequencer states of the top level
  typedef enum logic [3:0] {
    S_IDLE,
    S_ZEN,
    S_LAUNCH,
    S_EL,
    S_AZ_GO,
    S_AZ,
    S_WALK,
    S_MUL,
    S_ACC,
    S_OUT
  } state_t;

  // One input item
  typedef struct packed {
    logic               operation;
    logic [4:0]         entry_index;
    logic signed [23:0] entry_value;
    logic signed [15:0] elevation;
    logic [15:0]        azimuth;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic signed [25:0] correction;
    logic [4:0]         nearest_index;
  } result_t;

  // Zenith grid settings seen by the grid walker
  typedef struct packed {
    logic [14:0] zen_start;
    logic [14:0] zen_end;
    logic [14:0] zen_step;
    logic        present;
  } grid_cfg_t;

  localparam logic signed [25:0] CORR_MAX = 26'sh1FFFFFF;
  localparam logic signed [25:0] CORR_MIN = -26'sh2000000;

  // Arctangent table, 2^32 = full circle
  localparam int NUM_ATAN = 26;
  localparam logic [31:0] ATAN_TAB [NUM_ATAN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20
  };

endpackage

// ----- rtl/core/apcc_table.sv -----
module apcc_table import apcc_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic signed [23:0]             wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic signed [23:0]             rd_data
);

  logic signed [23:0] mem [TABLE_DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/apcc_cordic.sv -----
module apcc_cordic import apcc_pkg::*; #(
  parameter int TRIG_FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [15:0]                     angle,
  output logic                            done,
  output logic signed [TRIG_FRACTION_BITS+2:0] cos_out,
  output logic signed [TRIG_FRACTION_BITS+2:0] sin_out
);

  localparam int F  = TRIG_FRACTION_BITS;
  localparam int TW = F + 3;
  localparam int ZW = 33;
  localparam int N  = (F + 2 > NUM_ATAN) ? NUM_ATAN : F + 2;
  // Start vector carries the inverse gain
  localparam int X0 = (652032874 + (1 << (29 - F))) >> (30 - F);

  logic signed [TW-1:0] x, y, x_next, y_next, dx, dy;
  logic signed [ZW-1:0] z, z_next, z_init, z_fold, atan_v;
  logic                 flip, flip_init, running;
  logic [4:0]           iter;

  // Fold the start angle into [-90, 90] deg by a half turn
  always_comb begin
    z_init    = signed'({angle[15], angle, 16'b0});
    z_fold    = z_init;
    flip_init = 1'b0;
    if (z_init > (ZW'(1) <<< 30)) begin
      z_fold    = z_init - (ZW'(1) <<< 31);
      flip_init = 1'b1;
    end else if (z_init < -(ZW'(1) <<< 30)) begin
      z_fold    = z_init + (ZW'(1) <<< 31);
      flip_init = 1'b1;
    end
  end

  // One micro-rotation
  always_comb begin
    dx     = y >>> iter;
    dy     = x >>> iter;
    atan_v = signed'({1'b0, ATAN_TAB[iter]});
    if (z >= 0) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - atan_v;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + atan_v;
    end
  end

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      iter    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        iter    <= '0;
      end else if (running) begin
        if (iter == 5'(N - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          iter <= iter + 5'd1;
        end
      end
    end
  end

  // Rotation datapath and results
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= TW'(X0);
      y    <= '0;
      z    <= z_fold;
      flip <= flip_init;
    end else if (running) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
      if (iter == 5'(N - 1)) begin
        cos_out <= flip ? -x_next : x_next;
        sin_out <= flip ? -y_next : y_next;
      end
    end
  end

endmodule

// ----- rtl/core/apcc_walk.sv -----
module apcc_walk import apcc_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [16:0]             zen,
  input  grid_cfg_t                      cfg,
  output logic                           busy,
  output logic                           found,
  output logic [$clog2(TABLE_DEPTH)-1:0] idx
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [AW-1:0]      k;
  logic [16:0]        g;
  logic [17:0]        best, gap;
  logic signed [18:0] diff;

  // Distance of the current grid point from the zenith
  always_comb begin
    diff = signed'({2'b00, g}) - 19'(zen);
    gap  = (diff < 0) ? 18'(-diff) : 18'(diff);
  end

  // One grid point per cycle, earlier point wins ties
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      found <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      found <= 1'b0;
      k     <= '0;
      g     <= {2'b00, cfg.zen_start};
      best  <= 18'd100000;
      idx   <= '0;
    end else if (busy) begin
      if (!cfg.present || g > {2'b00, cfg.zen_end}) begin
        busy <= 1'b0;
      end else begin
        if (gap < best) begin
          best  <= gap;
          idx   <= k;
          found <= 1'b1;
        end
        if (cfg.zen_step == '0 || k == AW'(TABLE_DEPTH - 1)) begin
          busy <= 1'b0;
        end else begin
          k <= k + 1'b1;
          g <= g + {2'b00, cfg.zen_step};
        end
      end
    end
  end

endmodule

// ----- rtl/core/antenna_phase_center_correction.sv -----
// Antenna phase centre correction. A write item (operation 0) loads one
// entry of the zenith variation table and gives no result; a query
// item (operation 1) gives exactly one result, shown for a single cycle
// with result_valid, which the receiver must take as it comes. busy is
// high while a query is in progress, and start is ignored then. A query
// runs the single shared CORDIC unit for elevation and then azimuth;
// the grid walk of up to TABLE_DEPTH points runs alongside and lengthens
// the query only when it is the longer of the two. Configuration writes
// are always ready and must be made only while busy is low.
module antenna_phase_center_correction import apcc_pkg::*; #(
  parameter int TABLE_DEPTH        = 32,
  parameter int TRIG_FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output logic        result_valid,
  output result_t     result
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int F  = TRIG_FRACTION_BITS;
  localparam int TW = F + 3;
  localparam int MW = (TW > 24) ? TW : 24;
  localparam int PW = MW + TW;
  localparam int SW = PW + 2;
  localparam int CW = SW + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);

  // Product sequence steps
  localparam logic [2:0] MS_CAE   = 3'd0;
  localparam logic [2:0] MS_SAE   = 3'd1;
  localparam logic [2:0] MS_NORTH = 3'd2;
  localparam logic [2:0] MS_EAST  = 3'd3;
  localparam logic [2:0] MS_UP    = 3'd4;

  state_t state, state_next;

  grid_cfg_t          grid_cfg;
  logic signed [23:0] north_off, east_off, up_off;

  logic signed [15:0] el_q;
  logic [15:0]        az_q;
  logic [31:0]        zprod, zsum;
  logic signed [16:0] zen;

  logic                 walk_start, walk_busy, walk_found;
  logic [AW-1:0]        walk_idx;
  logic                 cord_start, cord_done;
  logic [15:0]          cord_angle;
  logic signed [TW-1:0] cord_cos, cord_sin;
  logic signed [TW-1:0] ce, se, ca, sa, cae, sae;

  logic               wr_en, rd_en;
  logic signed [23:0] rd_data, var_used;

  logic [2:0]           mstep;
  logic signed [MW-1:0] mul_a;
  logic signed [TW-1:0] mul_b;
  logic signed [PW-1:0] prod, prod_rnd;
  logic signed [SW-1:0] acc, tot_r;
  logic signed [CW-1:0] corr_full;
  logic signed [25:0]   corr_sat;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cfg.zen_start <= 15'd0;
      grid_cfg.zen_end   <= 15'd9000;
      grid_cfg.zen_step  <= 15'd500;
      grid_cfg.present   <= 1'b0;
      north_off          <= '0;
      east_off           <= '0;
      up_off             <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ZEN_START: grid_cfg.zen_start <= cfg_data[14:0];
        CFG_ZEN_END:   grid_cfg.zen_end   <= cfg_data[14:0];
        CFG_ZEN_STEP:  grid_cfg.zen_step  <= cfg_data[14:0];
        CFG_NORTH:     north_off          <= signed'(cfg_data);
        CFG_EAST:      east_off           <= signed'(cfg_data);
        CFG_UP:        up_off             <= signed'(cfg_data);
        CFG_PATTERN:   grid_cfg.present   <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // Table writes go straight in when the block is idle
  assign wr_en = start && !busy && (item.operation == OP_WRITE)
                 && (32'(item.entry_index) < TABLE_DEPTH);

  apcc_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(AW'(item.entry_index)),
    .wr_data(item.entry_value),
    .rd_en  (rd_en),
    .rd_addr(walk_idx),
    .rd_data(rd_data)
  );

  // Zenith in hundredths of a degree, rounded half down
  assign zsum = zprod + 32'd32768;
  assign zen  = 17'sd27000 - signed'({1'b0, zsum[31:16]});

  apcc_walk #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .start(walk_start),
    .zen  (zen),
    .cfg  (grid_cfg),
    .busy (walk_busy),
    .found(walk_found),
    .idx  (walk_idx)
  );

  apcc_cordic #(
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cord_start),
    .angle  (cord_angle),
    .done   (cord_done),
    .cos_out(cord_cos),
    .sin_out(cord_sin)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit strobes
  always_comb begin
    state_next = state;
    walk_start = 1'b0;
    cord_start = 1'b0;
    cord_angle = el_q;
    rd_en      = 1'b0;
    case (state)
      S_IDLE: begin
        if (start && item.operation == OP_QUERY) begin
          state_next = S_ZEN;
        end
      end
      S_ZEN:    state_next = S_LAUNCH;
      S_LAUNCH: begin
        walk_start = 1'b1;
        cord_start = 1'b1;
        state_next = S_EL;
      end
      S_EL: begin
        if (cord_done) begin
          state_next = S_AZ_GO;
        end
      end
      S_AZ_GO: begin
        cord_start = 1'b1;
        cord_angle = az_q;
        state_next = S_AZ;
      end
      S_AZ: begin
        if (cord_done) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (!walk_busy) begin
          rd_en      = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_ACC;
      S_ACC: begin
        state_next = (mstep == MS_UP) ? S_OUT : S_MUL;
      end
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Shared multiplier operands
  always_comb begin
    case (mstep)
      MS_CAE: begin
        mul_a = MW'(ca);
        mul_b = ce;
      end
      MS_SAE: begin
        mul_a = MW'(sa);
        mul_b = ce;
      end
      MS_NORTH: begin
        mul_a = MW'(north_off);
        mul_b = cae;
      end
      MS_EAST: begin
        mul_a = MW'(east_off);
        mul_b = sae;
      end
      MS_UP: begin
        mul_a = MW'(up_off);
        mul_b = se;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_rnd = (prod + HALF) >>> F;

  // Step counter of the product sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      mstep <= MS_CAE;
    end else if (state == S_WALK) begin
      mstep <= MS_CAE;
    end else if (state == S_ACC && mstep != MS_UP) begin
      mstep <= mstep + 3'd1;
    end
  end

  // Query datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        el_q <= item.elevation;
        az_q <= item.azimuth;
      end
      S_ZEN: zprod <= {16'b0, ~el_q[15], el_q[14:0]} * 32'd36000;
      S_EL: begin
        if (cord_done) begin
          ce <= cord_cos;
          se <= cord_sin;
        end
      end
      S_AZ: begin
        if (cord_done) begin
          ca <= cord_cos;
          sa <= cord_sin;
        end
      end
      S_MUL: prod <= mul_a * mul_b;
      S_ACC: begin
        case (mstep)
          MS_CAE:   cae <= TW'(prod_rnd);
          MS_SAE:   sae <= TW'(prod_rnd);
          MS_NORTH: acc <= SW'(prod);
          default:  acc <= acc + SW'(prod);
        endcase
      end
      default: ;
    endcase
  end

  // Final rounding, variation and saturation
  assign var_used  = walk_found ? rd_data : 24'sd0;
  assign tot_r     = (acc + SW'(HALF)) >>> F;
  assign corr_full = CW'(var_used) - CW'(tot_r);

  always_comb begin
    if (corr_full > CW'(CORR_MAX)) begin
      corr_sat = CORR_MAX;
    end else if (corr_full < CW'(CORR_MIN)) begin
      corr_sat = CORR_MIN;
    end else begin
      corr_sat = 26'(corr_full);
    end
  end

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      result.correction    <= corr_sat;
      result.nearest_index <= walk_found ? 5'(walk_idx) : 5'd0;
    end
  end

endmodule
